FILE: rtl/urlpd_pkg.sv
// Shared types, character codes and hex helpers for the percent decoder.
`default_nettype none
package urlpd_pkg;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // Maximum number of decoded bytes one input word can release.
   localparam int unsigned MAX_BYTES = 3;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_PERCENT,
      PHASE_DIGIT
   } phase_type;

   // One decoded run: the bytes released by a single input word.
   typedef struct packed {
      logic [1:0]                 count;     // 1 to 3 bytes
      logic [MAX_BYTES-1:0][7:0]  bytes;     // bytes[0] goes out first
      logic                       last;      // run closes the string
   } job_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

   function automatic logic hex_valid(input logic [7:0] b);
      logic ok;
      ok = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
      return ok;
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [3:0] v;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         v = 4'(b[2:0] + 3'd1) + 4'd8;
      end else begin
         v = 4'd0;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/urlpd_channels_if.sv
// Valid/ready channel interfaces for encoded input words and decoded output words.
`default_nettype none
interface urlpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface urlpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       string_end;

   modport source (output valid, output out_byte, output run_end, output string_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_end, input string_end,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/urlpd_front.sv
// Front end: accept input words, track the escape state and build decoded runs.
`default_nettype none
module urlpd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   urlpd_req_if.sink             req_ch,
   input  wire logic             queue_full,
   output      logic             push,
   output      urlpd_pkg::job_type push_job
);

   urlpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]           held_ff, held_in;

   logic       accept;
   logic       is_hex;
   logic [3:0] nibble;
   logic [1:0] prefix_cnt;
   logic       plain_emit;
   logic [7:0] plain_byte;
   logic       plain_run;
   logic       plain_pending;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;
   assign is_hex       = urlpd_pkg::hex_valid(req_ch.in_byte);
   assign nibble       = urlpd_pkg::hex_value(req_ch.in_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= urlpd_pkg::PHASE_IDLE;
         held_ff  <= 8'h00;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   // Ordinary-text handling of the incoming word.
   always_comb begin
      plain_emit    = 1'b1;
      plain_byte    = req_ch.in_byte;
      plain_pending = 1'b0;
      if (req_ch.in_byte == urlpd_pkg::CH_PLUS) begin
         plain_byte = urlpd_pkg::CH_SPACE;
      end else if (req_ch.in_byte == urlpd_pkg::CH_PERCENT && !req_ch.in_last) begin
         plain_emit    = 1'b0;
         plain_pending = 1'b1;
      end
   end

   always_comb begin
      phase_in       = urlpd_pkg::PHASE_IDLE;
      held_in        = held_ff;
      prefix_cnt     = 2'd0;
      plain_run      = 1'b1;
      push_job.bytes = '0;
      push_job.count = 2'd0;
      push_job.last  = req_ch.in_last;

      unique case (phase_ff)
         urlpd_pkg::PHASE_PERCENT: begin
            if (is_hex) begin
               plain_run = 1'b0;
               if (req_ch.in_last) begin
                  push_job.bytes[0] = urlpd_pkg::CH_PERCENT;
                  push_job.bytes[1] = req_ch.in_byte;
                  push_job.count    = 2'd2;
               end else begin
                  held_in  = req_ch.in_byte;
                  phase_in = urlpd_pkg::PHASE_DIGIT;
               end
            end else begin
               push_job.bytes[0] = urlpd_pkg::CH_PERCENT;
               prefix_cnt        = 2'd1;
            end
         end
         urlpd_pkg::PHASE_DIGIT: begin
            if (is_hex) begin
               plain_run         = 1'b0;
               push_job.bytes[0] = {urlpd_pkg::hex_value(held_ff), nibble};
               push_job.count    = 2'd1;
            end else begin
               push_job.bytes[0] = urlpd_pkg::CH_PERCENT;
               push_job.bytes[1] = held_ff;
               prefix_cnt        = 2'd2;
            end
         end
         default: begin
            prefix_cnt = 2'd0;
         end
      endcase

      if (plain_run) begin
         if (plain_emit) begin
            push_job.bytes[prefix_cnt] = plain_byte;
         end
         push_job.count = prefix_cnt + 2'(plain_emit);
         if (plain_pending) begin
            phase_in = urlpd_pkg::PHASE_PERCENT;
         end
      end

      // End of string flushes everything pending.
      if (req_ch.in_last) begin
         phase_in = urlpd_pkg::PHASE_IDLE;
      end
   end

   assign push = accept && (push_job.count != 2'd0);

endmodule
`default_nettype wire

FILE: rtl/urlpd_queue.sv
// Short FIFO of decoded runs between the front end and the back end.
`default_nettype none
module urlpd_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire urlpd_pkg::job_type push_job,
   output      logic               full,
   input  wire logic               pop,
   output      urlpd_pkg::head_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   urlpd_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/urlpd_back.sv
// Back end: walk each queued run and drive one decoded word per cycle while the receiver is ready.
`default_nettype none
module urlpd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire urlpd_pkg::head_type head,
   output      logic                pop,
   urlpd_rsp_if.source              rsp_ch
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       run_end_ff;
   logic       string_end_ff;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       final_byte;

   assign load       = head.valid && (!valid_ff || rsp_ch.ready);
   assign final_byte = (idx_ff == head.job.count - 2'd1);
   assign pop        = load && final_byte;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = final_byte ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= head.job.bytes[idx_ff];
         run_end_ff    <= final_byte;
         string_end_ff <= final_byte && head.job.last;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.out_byte   = byte_ff;
   assign rsp_ch.run_end    = run_end_ff;
   assign rsp_ch.string_end = string_end_ff;

endmodule
`default_nettype wire

FILE: rtl/url_percent_decoder_core.sv
// Top level of the streaming percent decoder.
//
//   channel   dir  payload                        accepted when
//   req_ch    in   in_byte[7:0], in_last          req_ch.valid && req_ch.ready
//   rsp_ch    out  out_byte[7:0], run_end,        rsp_ch.valid && rsp_ch.ready
//                  string_end
//
// Throughput: one input word a cycle while each word releases at most one decoded word and
//   the receiver is ready; a word releasing two or three decoded words keeps the single output
//   register busy with each of them in turn, since it drains one word a cycle while ready.
// Path: a run enters the run queue at the edge that accepts its input word; its first
//   decoded word turns valid when the output register loads it from the queue head,
//   which waits while the register holds a word the receiver has not taken.
// Reset clears the escape state, empties the run queue and clears the output valid flag.
// Stalls: input ready drops only when the run queue is full; the output side stalls
//   independently through the queue.
`default_nettype none
module url_percent_decoder_core #(
   parameter int unsigned QUEUE_DEPTH = 2   // runs buffered between front and back, >= 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   urlpd_req_if.sink    req_ch,
   urlpd_rsp_if.source  rsp_ch
);

   logic                 push;
   logic                 pop;
   logic                 queue_full;
   urlpd_pkg::job_type   push_job;
   urlpd_pkg::head_type  head;

   // Classify each word against the pending escape and form its decoded run.
   urlpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // Hold finished runs so the front keeps taking words while output stalls, until the queue is full.
   urlpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head     (head)
   );

   // Drain each run one decoded word at a time, flagging run and string ends.
   urlpd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
`default_nettype wire

FILE: tb/sv/url_percent_decoder_core_tb.sv
// Self-checking testbench for the streaming percent decoder core.
`timescale 1ns / 1ps
`default_nettype none
module url_percent_decoder_core_tb;

   // One decoded word as the output channel presents it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       string_end;
   } decoded_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   urlpd_req_if req_ch ();
   urlpd_rsp_if rsp_ch ();

   url_percent_decoder_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predictor state: pending escape and the held first digit.
   urlpd_pkg::phase_type esc_phase;
   logic [7:0]  pending_digit;
   logic [7:0]  run_bytes[$];      // decoded bytes released by the current input word
   decoded_type decoded_q[$];      // decoded words still owed by the block

   logic [7:0] enc_text[$];       // encoded string being assembled for sending

   int mismatches    = 0;
   int words_in      = 0;
   int words_out     = 0;
   int strings_sent  = 0;
   int input_stalls  = 0;
   bit quiet         = 1'b0;      // suppress idling on both sides
   int rsp_hold_req  = 0;         // long receiver hold-off requested by a test

   // Clock: 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
   endtask

   // Append to the run being predicted, the string being built and the owed words.
   task automatic add_run_byte(input logic [7:0] b);
      run_bytes.insert(run_bytes.size(), b);
   endtask

   task automatic add_enc_byte(input logic [7:0] b);
      enc_text.insert(enc_text.size(), b);
   endtask

   task automatic add_owed_word(input decoded_type d);
      decoded_q.insert(decoded_q.size(), d);
   endtask

   // -1 for a byte that is no hex digit, else its value.
   function automatic int hex_nibble(input logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - 48;
      if (b >= "a" && b <= "f") return int'(b) - 87;
      if (b >= "A" && b <= "F") return int'(b) - 55;
      return -1;
   endfunction

   // Decode a byte as ordinary text with nothing pending.
   task automatic decode_plain(input logic [7:0] b, input logic last);
      if (b == urlpd_pkg::CH_PLUS) begin
         add_run_byte(urlpd_pkg::CH_SPACE);
         esc_phase = urlpd_pkg::PHASE_IDLE;
      end else if (b == urlpd_pkg::CH_PERCENT) begin
         if (last) begin
            add_run_byte(urlpd_pkg::CH_PERCENT);
            esc_phase = urlpd_pkg::PHASE_IDLE;
         end else begin
            esc_phase = urlpd_pkg::PHASE_PERCENT;
         end
      end else begin
         add_run_byte(b);
         esc_phase = urlpd_pkg::PHASE_IDLE;
      end
   endtask

   // Advance the predictor by one accepted input word and queue what it releases.
   task automatic decode_word(input logic [7:0] b, input logic last);
      int v;
      int hv;
      int n;
      decoded_type d;
      run_bytes.delete();
      v = hex_nibble(b);
      case (esc_phase)
         urlpd_pkg::PHASE_PERCENT: begin
            if (v >= 0) begin
               if (last) begin
                  add_run_byte(urlpd_pkg::CH_PERCENT);
                  add_run_byte(b);
                  esc_phase = urlpd_pkg::PHASE_IDLE;
               end else begin
                  pending_digit = b;
                  esc_phase     = urlpd_pkg::PHASE_DIGIT;
               end
            end else begin
               add_run_byte(urlpd_pkg::CH_PERCENT);
               decode_plain(b, last);
            end
         end
         urlpd_pkg::PHASE_DIGIT: begin
            if (v >= 0) begin
               hv = hex_nibble(pending_digit);
               if (hv < 0) hv = 0;
               add_run_byte({hv[3:0], v[3:0]});
               esc_phase = urlpd_pkg::PHASE_IDLE;
            end else begin
               add_run_byte(urlpd_pkg::CH_PERCENT);
               add_run_byte(pending_digit);
               decode_plain(b, last);
            end
            pending_digit = 8'h00;
         end
         default: begin
            decode_plain(b, last);
         end
      endcase
      if (last) begin
         esc_phase     = urlpd_pkg::PHASE_IDLE;
         pending_digit = 8'h00;
      end
      n = run_bytes.size();
      for (int i = 0; i < n; i++) begin
         d.out_byte   = run_bytes[i];
         d.run_end    = (i == n - 1);
         d.string_end = (i == n - 1) && last;
         add_owed_word(d);
      end
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   // Offer one encoded word and hold it until the block takes it.
   task automatic send_word(input logic [7:0] b, input logic last);
      int gap;
      gap = idle_gap();
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.in_last <= last;
      @(posedge clock);
      while (!req_ch.ready) begin
         input_stalls++;
         @(posedge clock);
      end
      words_in++;
      if (last) strings_sent++;
      decode_word(b, last);
   endtask

   // Send the assembled string, flagging its final byte.
   task automatic send_text();
      for (int i = 0; i < enc_text.size(); i++) begin
         send_word(enc_text[i], i == enc_text.size() - 1);
      end
      enc_text.delete();
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_enc_byte(s[i]);
      end
      send_text();
   endtask

   // Non-hex bytes right next to the hex ranges, plus the byte extremes.
   function automatic logic [7:0] boundary_char();
      case ($urandom_range(0, 7))
         0: return 8'h2F;
         1: return 8'h3A;
         2: return 8'h40;
         3: return 8'h47;
         4: return 8'h60;
         5: return 8'h67;
         6: return 8'h00;
         default: return 8'hFF;
      endcase
   endfunction

   function automatic logic [7:0] random_hex_char();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return 8'(48 + r);
      if (r < 16) return 8'(87 + r);
      return 8'(49 + r);
   endfunction

   // Build a string from random tokens: valid escapes, plus signs, broken escapes and plain bytes.
   task automatic compose_string(input int tokens);
      int r;
      repeat (tokens) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            add_enc_byte(urlpd_pkg::CH_PERCENT);
            add_enc_byte(random_hex_char());
            add_enc_byte(random_hex_char());
         end else if (r < 45) begin
            add_enc_byte(urlpd_pkg::CH_PLUS);
         end else if (r < 55) begin
            add_enc_byte(urlpd_pkg::CH_PERCENT);
            if ($urandom_range(0, 1)) add_enc_byte(random_hex_char());
            add_enc_byte($urandom_range(0, 3) == 0 ? urlpd_pkg::CH_PERCENT
                                                   : boundary_char());
         end else if (r < 65) begin
            add_enc_byte(boundary_char());
         end else begin
            add_enc_byte(8'($urandom_range(0, 255)));
         end
      end
      // Cut an escape short at the end of the string now and then.
      r = $urandom_range(0, 9);
      if (r == 0) begin
         add_enc_byte(urlpd_pkg::CH_PERCENT);
      end else if (r == 1) begin
         add_enc_byte(urlpd_pkg::CH_PERCENT);
         add_enc_byte(random_hex_char());
      end
   endtask

   // Drop the offer, then wait for every owed word to come out.
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
   endtask

   // Edge cases: plus, escapes in both cases, broken and cut-short escapes, byte extremes.
   task automatic test_directed();
      send_string("a+b");
      send_string("%41");     // escape closes exactly on the last byte
      send_string("%");       // lone percent flushed at the end
      send_string("%4");      // percent and digit flushed at the end
      send_string("%zq");     // percent then non-hex
      send_string("%4+x");    // percent, digit, then plus
      send_string("%%fF");    // broken escape, then one in mixed case
      send_string("%%");
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_strings();
      int start;
      start = words_in;
      while (words_in - start < 120) begin
         compose_string($urandom_range(1, 6));
         send_text();
      end
      wait_drained();
   endtask

   // Hold the receiver off while the sender keeps offering, so the run queue fills.
   task automatic test_output_pressure();
      quiet        = 1'b1;
      rsp_hold_req = 60;
      repeat (3) begin
         add_enc_byte(urlpd_pkg::CH_PERCENT);
         add_enc_byte(urlpd_pkg::CH_PERCENT);
         add_enc_byte(8'h31);
         add_enc_byte(8'h2F);
         compose_string(2);
      end
      send_text();
      wait_drained();
      quiet = 1'b0;
   endtask

   // A stretch with no idling on either side.
   task automatic test_back_to_back();
      quiet = 1'b1;
      repeat (8) begin
         compose_string($urandom_range(1, 4));
         send_text();
      end
      wait_drained();
      quiet = 1'b0;
   endtask

   // Receiver: drive ready at the falling edge, with random stalls and requested hold-offs.
   initial begin
      int hold;
      int stall;
      int r;
      hold  = 0;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req > 0) begin
            hold         = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else if (quiet) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_ch.ready <= 1'b1;
            end else if (r < 95) begin
               rsp_ch.ready <= 1'b0;
               stall = $urandom_range(0, 2);
            end else begin
               rsp_ch.ready <= 1'b0;
               stall = $urandom_range(8, 25);
            end
         end
      end
   end

   // Check each accepted decoded word against the oldest expectation.
   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         words_out++;
         if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word %02h", rsp_ch.out_byte));
         end else begin
            want = decoded_q.pop_front();
            if (rsp_ch.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, want %02h",
                                         rsp_ch.out_byte, want.out_byte));
            if (rsp_ch.run_end !== want.run_end)
               report_mismatch($sformatf("run_end %b, want %b on byte %02h",
                                         rsp_ch.run_end, want.run_end, want.out_byte));
            if (rsp_ch.string_end !== want.string_end)
               report_mismatch($sformatf("string_end %b, want %b on byte %02h",
                                         rsp_ch.string_end, want.string_end,
                                         want.out_byte));
         end
      end
   end

   // Watchdog: stop a hung run.
   initial begin
      #5_000_000;
      $display("timeout: %0d decoded words still owed", decoded_q.size());
      $display("url_percent_decoder_core: mismatch");
      $finish;
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.in_byte = 8'h00;
      req_ch.in_last = 1'b0;
      esc_phase      = urlpd_pkg::PHASE_IDLE;
      pending_digit  = 8'h00;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_strings();
      test_output_pressure();
      test_back_to_back();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);

      $display("sent %0d encoded words in %0d strings, checked %0d decoded words",
               words_in, strings_sent, words_out);
      $display("escapes, broken and cut-short escapes, random text, %0d input stall cycles",
               input_stalls);
      if (mismatches == 0) begin
         $display("url_percent_decoder_core: match");
      end else begin
         $display("url_percent_decoder_core: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
rtl/urlpd_pkg.sv
rtl/urlpd_channels_if.sv
rtl/urlpd_front.sv
rtl/urlpd_queue.sv
rtl/urlpd_back.sv
rtl/url_percent_decoder_core.sv
tb/sv/url_percent_decoder_core_tb.sv
